@@ rtl/core/exercise_rep_counter_unit_defines.svh @@
// Assertion macros shared by the exercise repetition counter RTL.
// Files that check their own logic include this header; no other dependency.
`ifndef EXERCISE_REP_COUNTER_UNIT_DEFINES_SVH
`define EXERCISE_REP_COUNTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// check on every clock edge outside reset
`define ERCU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check on every clock edge, reset included
`define ERCU_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ERCU_ASSERT(label, prop, msg)
`define ERCU_ASSERT_RST(label, prop, msg)
`endif
`endif

@@ rtl/core/ercu_pkg.sv @@
// Shared types, codes and window constants for the exercise repetition counter.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps
package ercu_pkg;

	localparam int unsigned WINDOW_DEF = 20;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam int unsigned ANGLE_W = 9;
	localparam int unsigned ANGLE_MAX = (1 << ANGLE_W) - 1;
	localparam int unsigned TEST_W = ANGLE_W + 1;

	typedef struct packed {
		logic [ANGLE_W-1:0] roll_deg;
		logic [ANGLE_W-1:0] pitch_deg;
		logic               raise_target;
	} in_item_t;

	typedef struct packed {
		logic [2:0] motion_state;
		logic [2:0] completed_exercise;
		logic [7:0] completed_count;
		logic [7:0] current_target;
		logic       led_situp_on;
		logic       led_pushup_on;
		logic       led_squat_on;
		logic       led_jump_on;
		logic       blink_pulse;
		logic       timed_out;
	} out_item_t;

	// posture tests decided in the front, consumed by the posture machine
	typedef struct packed {
		logic raise;
		logic upright_raw;
		logic lying_in;
		logic lying_done;
		logic squat_in;
		logic jack_in;
		logic pushup_in;
		logic upright_avg;
		logic jack_vert;
	} cls_t;

	typedef enum logic [1:0] {
		CFG_INITIAL_TARGET = 2'd0,
		CFG_TARGET_STEP    = 2'd1,
		CFG_TIMEOUT        = 2'd2
	} cfg_index_t;

	typedef enum logic [7:0] {
		P_IDLE    = 8'b0000_0001,
		P_LYING   = 8'b0000_0010,
		P_STAND   = 8'b0000_0100,
		P_SQUAT   = 8'b0000_1000,
		P_PUSHUP  = 8'b0001_0000,
		P_JACK_H1 = 8'b0010_0000,
		P_JACK_V  = 8'b0100_0000,
		P_JACK_H2 = 8'b1000_0000
	} posture_t;

	localparam logic [2:0] MS_IDLE    = 3'd0;
	localparam logic [2:0] MS_LYING   = 3'd1;
	localparam logic [2:0] MS_STAND   = 3'd2;
	localparam logic [2:0] MS_SQUAT   = 3'd3;
	localparam logic [2:0] MS_PUSHUP  = 3'd4;
	localparam logic [2:0] MS_JACK_H1 = 3'd5;
	localparam logic [2:0] MS_JACK_V  = 3'd6;
	localparam logic [2:0] MS_JACK_H2 = 3'd7;

	typedef enum logic [2:0] {
		EX_NONE   = 3'd0,
		EX_SITUP  = 3'd1,
		EX_SQUAT  = 3'd2,
		EX_PUSHUP = 3'd3,
		EX_JACK   = 3'd4
	} exercise_t;

	localparam logic [7:0]  TARGET_RST  = 8'd5;
	localparam logic [7:0]  STEP_RST    = 8'd5;
	localparam logic [15:0] TIMEOUT_RST = 16'd300;

	// centre / tolerance windows
	localparam logic [TEST_W-1:0] UPRIGHT_ROLL_C = 10'd105, UPRIGHT_ROLL_T = 10'd25;
	localparam logic [TEST_W-1:0] UPRIGHT_PITCH_C = 10'd165, UPRIGHT_PITCH_T = 10'd20;
	localparam logic [TEST_W-1:0] LYING_ROLL_C = 10'd320, LYING_PITCH_C = 10'd292;
	localparam logic [TEST_W-1:0] LYING_T = 10'd40;
	localparam logic [TEST_W-1:0] SITUP_ROLL_C = 10'd205, SITUP_PITCH_C = 10'd320;
	localparam logic [TEST_W-1:0] SITUP_T = 10'd15;
	localparam logic [TEST_W-1:0] SQUAT_ROLL_C = 10'd170, SQUAT_ROLL_T = 10'd10;
	localparam logic [TEST_W-1:0] SQUAT_PITCH_C = 10'd110, SQUAT_PITCH_T = 10'd35;
	localparam logic [TEST_W-1:0] PUSHUP_ROLL_C = 10'd50, PUSHUP_PITCH_C = 10'd110;
	localparam logic [TEST_W-1:0] PUSHUP_T = 10'd20;
	localparam logic [TEST_W-1:0] JACK_H_ROLL_C = 10'd175, JACK_H_ROLL_T = 10'd15;
	localparam logic [TEST_W-1:0] JACK_H_PITCH_MAX = 10'd65;
	localparam logic [TEST_W-1:0] JACK_V_ROLL_C = 10'd180, JACK_V_ROLL_T = 10'd10;
	localparam logic [TEST_W-1:0] JACK_V_PITCH_C = 10'd30, JACK_V_PITCH_T = 10'd15;
	localparam logic [TEST_W-1:0] JACK_V_OFFSET = 10'd30;
	localparam logic [TEST_W-1:0] FULL_TURN = 10'd360;

	// |v - c| < t, written without a sign; v + t stays below 1024
	function automatic logic near(input logic [TEST_W-1:0] v, input logic [TEST_W-1:0] c,
			input logic [TEST_W-1:0] t);
		near = ((v + t) > c) && (v < (c + t));
	endfunction

endpackage

@@ rtl/core/ercu_front.sv @@
// Front end: sample ring, running sums, averages and posture window tests.
// Depends on ercu_pkg; feeds the class queue (ercu_fifo).
`timescale 1ns / 1ps
module ercu_front #(
	parameter int unsigned WINDOW = ercu_pkg::WINDOW_DEF,
	parameter int unsigned QUEUE_DEPTH = ercu_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ercu_pkg::in_item_t in_data,
	input  logic [LVL_W-1:0]   q_level,
	output logic               q_push,
	output ercu_pkg::cls_t     q_data
);
	import ercu_pkg::*;

	localparam int unsigned SUM_W = $clog2(WINDOW * ANGLE_MAX + 1);
	localparam int unsigned SHIFT = SUM_W + $clog2(WINDOW);
	// reciprocal rounded up; exact for every sum below 2**SUM_W
	localparam int unsigned MUL = ((1 << SHIFT) + WINDOW - 1) / WINDOW;
	localparam int unsigned PROD_W = SUM_W + $clog2(MUL + 1);

	logic [ANGLE_W-1:0] roll_tap_q [WINDOW];
	logic [ANGLE_W-1:0] pitch_tap_q [WINDOW];
	logic [SUM_W-1:0]   roll_sum_q;
	logic [SUM_W-1:0]   pitch_sum_q;
	logic               valid_s1;
	logic               raise_s1;
	logic               in_fire;

	logic [ANGLE_W-1:0]  a2r, a2p, awr, awp;
	logic [PROD_W-1:0]   prod_r, prod_p;
	logic [TEST_W-1:0]   p30, pmod;
	logic [TEST_W-1:0]   roll_w, pitch_w, a2r_w, a2p_w, awr_w, awp_w;

	// reserve a queue slot for the beat in stage 1
	assign in_ready = ((LVL_W + 1)'(q_level) + (LVL_W + 1)'(valid_s1))
		< (LVL_W + 1)'(QUEUE_DEPTH);
	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				roll_tap_q[i] <= '0;
				pitch_tap_q[i] <= '0;
			end
			roll_sum_q <= '0;
			pitch_sum_q <= '0;
			valid_s1 <= 1'b0;
			raise_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
			if (in_fire) begin
				raise_s1 <= in_data.raise_target;
				// drop the oldest sample, add the new one
				roll_sum_q <= roll_sum_q - SUM_W'(roll_tap_q[WINDOW-1])
					+ SUM_W'(in_data.roll_deg);
				pitch_sum_q <= pitch_sum_q - SUM_W'(pitch_tap_q[WINDOW-1])
					+ SUM_W'(in_data.pitch_deg);
				for (int i = WINDOW - 1; i > 0; i--) begin
					roll_tap_q[i] <= roll_tap_q[i-1];
					pitch_tap_q[i] <= pitch_tap_q[i-1];
				end
				roll_tap_q[0] <= in_data.roll_deg;
				pitch_tap_q[0] <= in_data.pitch_deg;
			end
		end
	end

	// stage 1 reads the ring and sums right after they took the sample
	always_comb begin
		a2r = ANGLE_W'(({1'b0, roll_tap_q[0]} + {1'b0, roll_tap_q[1]}) >> 1);
		a2p = ANGLE_W'(({1'b0, pitch_tap_q[0]} + {1'b0, pitch_tap_q[1]}) >> 1);
		prod_r = PROD_W'(roll_sum_q) * PROD_W'(MUL);
		prod_p = PROD_W'(pitch_sum_q) * PROD_W'(MUL);
		awr = ANGLE_W'(prod_r >> SHIFT);
		awp = ANGLE_W'(prod_p >> SHIFT);
		roll_w = TEST_W'(roll_tap_q[0]);
		pitch_w = TEST_W'(pitch_tap_q[0]);
		a2r_w = TEST_W'(a2r);
		a2p_w = TEST_W'(a2p);
		awr_w = TEST_W'(awr);
		awp_w = TEST_W'(awp);
		p30 = pitch_w + JACK_V_OFFSET;
		pmod = (p30 >= FULL_TURN) ? (p30 - FULL_TURN) : p30;

		q_data.raise = raise_s1;
		q_data.upright_raw = near(roll_w, UPRIGHT_ROLL_C, UPRIGHT_ROLL_T)
			&& near(pitch_w, UPRIGHT_PITCH_C, UPRIGHT_PITCH_T);
		q_data.lying_in = near(a2r_w, LYING_ROLL_C, LYING_T)
			&& near(a2p_w, LYING_PITCH_C, LYING_T);
		q_data.lying_done = near(a2r_w, SITUP_ROLL_C, SITUP_T)
			&& near(a2p_w, SITUP_PITCH_C, SITUP_T);
		q_data.squat_in = near(awr_w, SQUAT_ROLL_C, SQUAT_ROLL_T)
			&& near(a2r_w, SQUAT_ROLL_C, SQUAT_ROLL_T)
			&& near(awp_w, SQUAT_PITCH_C, SQUAT_PITCH_T)
			&& near(a2p_w, SQUAT_PITCH_C, SQUAT_PITCH_T);
		q_data.jack_in = near(roll_w, JACK_H_ROLL_C, JACK_H_ROLL_T)
			&& (a2p_w <= JACK_H_PITCH_MAX);
		q_data.pushup_in = near(a2r_w, PUSHUP_ROLL_C, PUSHUP_T)
			&& near(a2p_w, PUSHUP_PITCH_C, PUSHUP_T);
		q_data.upright_avg = near(a2r_w, UPRIGHT_ROLL_C, UPRIGHT_ROLL_T)
			&& near(a2p_w, UPRIGHT_PITCH_C, UPRIGHT_PITCH_T);
		q_data.jack_vert = near(roll_w, JACK_V_ROLL_C, JACK_V_ROLL_T)
			&& near(pmod, JACK_V_PITCH_C, JACK_V_PITCH_T);
	end

	assign q_push = valid_s1;

endmodule

@@ rtl/core/ercu_fifo.sv @@
// Class queue between the front end and the posture machine.
// Depends on ercu_pkg and the shared assertion macros header.
`timescale 1ns / 1ps
`include "exercise_rep_counter_unit_defines.svh"
module ercu_fifo #(
	parameter int unsigned DEPTH = ercu_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned LVL_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ercu_pkg::cls_t   wr_data,
	input  logic             pop,
	output ercu_pkg::cls_t   rd_data,
	output logic             rd_valid,
	output logic [LVL_W-1:0] level
);
	import ercu_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cls_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: level_q <= level_q + 1'b1;
				2'b01: level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign rd_valid = (level_q != '0);
	assign level = level_q;

	`ERCU_ASSERT(a_no_overflow, push |-> (level_q < LVL_W'(DEPTH)), "queue push while full")
	`ERCU_ASSERT(a_no_underflow, pop |-> (level_q != '0), "queue pop while empty")
	`ERCU_ASSERT_RST(a_rst_empty, !arst_n |=> (level_q == '0), "queue not empty after reset")

endmodule

@@ rtl/core/ercu_back.sv @@
// Back end: posture machine, timeout, repetition counts, target, LEDs, result register.
// Depends on ercu_pkg and the shared assertion macros header.
`timescale 1ns / 1ps
`include "exercise_rep_counter_unit_defines.svh"
module ercu_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  ercu_pkg::cls_t      q_data,
	output logic                q_pop,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ercu_pkg::out_item_t out_data
);
	import ercu_pkg::*;

	posture_t    posture_q;
	logic [15:0] idle_q;
	logic [7:0]  target_q;
	logic [7:0]  step_q;
	logic [15:0] timeout_q;
	logic [7:0]  cnt_q [4];
	logic [3:0]  led_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [8:0]  tgt_sum;
	logic [7:0]  tgt_new;
	logic [3:0]  led_mid;
	logic [3:0]  led_new;
	logic [7:0]  cnt_new [4];
	logic        tout;
	posture_t    cur;
	posture_t    nxt;
	exercise_t   done;
	logic [1:0]  ex_idx;
	logic        moved;
	logic        blink;
	logic [7:0]  done_cnt;
	logic [15:0] idle_new;
	logic [2:0]  ms_code;

	assign q_pop = q_valid && (!out_valid_q || out_ready);

	always_comb begin
		tgt_sum = {1'b0, target_q} + {1'b0, step_q};
		tgt_new = q_data.raise ? ((tgt_sum > 9'd255) ? 8'd255 : tgt_sum[7:0]) : target_q;
		for (int i = 0; i < 4; i++) begin
			led_mid[i] = q_data.raise ? (cnt_q[i] < tgt_new) : led_q[i];
		end

		// timeout forces idle before the machine looks at this sample
		tout = (idle_q >= timeout_q);
		cur = tout ? P_IDLE : posture_q;
		nxt = cur;
		done = EX_NONE;
		unique case (cur)
			P_IDLE: begin
				if (q_data.upright_raw) begin
					nxt = P_STAND;
				end else if (q_data.lying_in) begin
					nxt = P_LYING;
				end
			end
			P_LYING: begin
				if (q_data.lying_done) begin
					nxt = P_IDLE;
					done = EX_SITUP;
				end
			end
			P_STAND: begin
				if (q_data.squat_in) begin
					nxt = P_SQUAT;
				end else if (q_data.jack_in) begin
					nxt = P_JACK_H1;
				end else if (q_data.pushup_in) begin
					nxt = P_PUSHUP;
				end
			end
			P_SQUAT: begin
				if (q_data.upright_avg) begin
					nxt = P_IDLE;
					done = EX_SQUAT;
				end
			end
			P_PUSHUP: begin
				if (q_data.upright_avg) begin
					nxt = P_IDLE;
					done = EX_PUSHUP;
				end
			end
			P_JACK_H1: begin
				if (q_data.jack_vert) begin
					nxt = P_JACK_V;
				end
			end
			P_JACK_V: begin
				if (q_data.jack_in) begin
					nxt = P_JACK_H2;
				end
			end
			P_JACK_H2: begin
				if (q_data.upright_raw) begin
					nxt = P_IDLE;
					done = EX_JACK;
				end
			end
			default: nxt = P_IDLE;
		endcase
		moved = (nxt != cur) || (done != EX_NONE);

		ex_idx = 2'(done - 3'd1);
		led_new = led_mid;
		blink = 1'b0;
		done_cnt = 8'd0;
		for (int i = 0; i < 4; i++) begin
			cnt_new[i] = cnt_q[i];
		end
		if (done != EX_NONE) begin
			if (({1'b0, cnt_q[ex_idx]} + 9'd1) == {1'b0, tgt_new}) begin
				led_new[ex_idx] = 1'b0;
				cnt_new[ex_idx] = cnt_q[ex_idx] + 8'd1;
			end else if (cnt_q[ex_idx] < tgt_new) begin
				led_new[ex_idx] = 1'b1;
				cnt_new[ex_idx] = cnt_q[ex_idx] + 8'd1;
				blink = 1'b1;
			end
			done_cnt = cnt_new[ex_idx];
		end

		if (moved) begin
			idle_new = 16'd0;
		end else if (tout) begin
			idle_new = 16'd1;
		end else begin
			idle_new = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
		end

		unique case (nxt)
			P_IDLE:    ms_code = MS_IDLE;
			P_LYING:   ms_code = MS_LYING;
			P_STAND:   ms_code = MS_STAND;
			P_SQUAT:   ms_code = MS_SQUAT;
			P_PUSHUP:  ms_code = MS_PUSHUP;
			P_JACK_H1: ms_code = MS_JACK_H1;
			P_JACK_V:  ms_code = MS_JACK_V;
			P_JACK_H2: ms_code = MS_JACK_H2;
			default:   ms_code = MS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			posture_q <= P_IDLE;
			idle_q <= 16'd0;
			target_q <= TARGET_RST;
			step_q <= STEP_RST;
			timeout_q <= TIMEOUT_RST;
			for (int i = 0; i < 4; i++) begin
				cnt_q[i] <= 8'd0;
			end
			led_q <= 4'hF;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				posture_q <= nxt;
				idle_q <= idle_new;
				target_q <= tgt_new;
				for (int i = 0; i < 4; i++) begin
					cnt_q[i] <= cnt_new[i];
				end
				led_q <= led_new;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_INITIAL_TARGET: target_q <= cfg_data[7:0];
					CFG_TARGET_STEP:    step_q <= cfg_data[7:0];
					CFG_TIMEOUT:        timeout_q <= cfg_data;
					default:            ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q.motion_state <= ms_code;
			out_q.completed_exercise <= done;
			out_q.completed_count <= done_cnt;
			out_q.current_target <= tgt_new;
			out_q.led_situp_on <= led_new[0];
			out_q.led_squat_on <= led_new[1];
			out_q.led_pushup_on <= led_new[2];
			out_q.led_jump_on <= led_new[3];
			out_q.blink_pulse <= blink;
			out_q.timed_out <= tout;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`ERCU_ASSERT(a_done_to_idle, (q_pop && (done != EX_NONE)) |=> (posture_q == P_IDLE), "completion left posture busy")
	`ERCU_ASSERT(a_blink_needs_done, (q_pop && blink) |-> (done != EX_NONE), "blink without a completed repetition")
	`ERCU_ASSERT(a_idle_count, (q_pop && !moved && !tout && (idle_q != 16'hFFFF)) |=> (idle_q == ($past(idle_q) + 16'd1)), "idle counter did not advance")

endmodule

@@ rtl/core/exercise_rep_counter_unit.sv @@
// Top level of the exercise repetition counter: front end, class queue, back end.
// Depends on ercu_pkg, ercu_front, ercu_fifo and ercu_back.
`timescale 1ns / 1ps
// One roll/pitch sample is taken per cycle while in_ready is high; one result beat per
// sample passes the stage 1 register, the queue and the result register and leaves when
// the output side is ready. The front end keeps the last WINDOW samples in a shift line
// with running sums, so the two averages and all posture window tests resolve in a single
// stage; the posture machine, counts and target update once per beat. A QUEUE_DEPTH beat
// queue sits between the two halves: in_ready drops once the queue plus the front stage
// hold QUEUE_DEPTH beats. Configuration writes are always ready; write them only while no
// sample is in flight. Writing the initial target also loads the active target.
module exercise_rep_counter_unit #(
	parameter int unsigned WINDOW = ercu_pkg::WINDOW_DEF,
	parameter int unsigned QUEUE_DEPTH = ercu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ercu_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ercu_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import ercu_pkg::*;

	localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);

	logic             q_push;
	logic             q_pop;
	logic             q_valid;
	logic [LVL_W-1:0] q_level;
	cls_t             q_wr_data;
	cls_t             q_rd_data;

	assign cfg_ready = 1'b1;

	ercu_front #(
		.WINDOW(WINDOW),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.LVL_W(LVL_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.q_level(q_level),
		.q_push(q_push),
		.q_data(q_wr_data)
	);

	ercu_fifo #(
		.DEPTH(QUEUE_DEPTH),
		.LVL_W(LVL_W)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wr_data(q_wr_data),
		.pop(q_pop),
		.rd_data(q_rd_data),
		.rd_valid(q_valid),
		.level(q_level)
	);

	ercu_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_data(q_rd_data),
		.q_pop(q_pop),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule
